// ----- design/rrte_pkg.sv -----
// Shared types and constants for the route table engine.
// No dependencies; used by the controller, the datapath and the top level.
package rrte_pkg;

  localparam int unsigned CFG_W = 16;

  // Action codes of a request; codes above ACT_DOWN do nothing.
  localparam logic [2:0] ACT_RX   = 3'd0;
  localparam logic [2:0] ACT_TICK = 3'd1;
  localparam logic [2:0] ACT_ADV  = 3'd2;
  localparam logic [2:0] ACT_UP   = 3'd3;
  localparam logic [2:0] ACT_DOWN = 3'd4;

  // Lowest and highest of the reserved codes that leave the table alone.
  localparam logic [2:0] ACT_RSVD_LO = 3'd5;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_INFINITY = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic [7:0]  INF_RESET     = 8'd16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd20;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  metric;
    logic [1:0]  port;
    logic [31:0] stamp;
  } route_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_EVAL,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic eval;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic scan;
    logic eval_last;
    logic eval_hold;
    logic out_free;
  } sts_t;

endpackage

// ----- design/rip_route_table_engine_top.sv -----
// Top level of the RIP route table engine: controller plus datapath.
// Depends on rrte_pkg, rrte_ctrl and rrte_dp.
//
// Each request of a known action (a port below NUM_PORTS for receive, up and
// down) scans the routes in use in append order, each route by a registered
// RAM read and then an evaluate/write-back step, between a load step and a
// final completion step. A received entry ends its scan at the first matching
// route, an advertisement after MAX_ADVERT advertised routes. The table RAM
// gives one route per registered read. An advertisement also waits whenever a
// route is ready while the previous result is still held by the consumer, and
// every request waits in its final step until the result register is free. A
// full-table append is dropped and reported with status 1.
module rip_route_table_engine_top
  import rrte_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_ADVERT  = 25,
  parameter int NUM_PORTS   = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [2:0]       action,
  input  logic [31:0]      dst_addr,
  input  logic [31:0]      dest_mask,
  input  logic [31:0]      metric_in,
  input  logic [31:0]      sender_ip,
  input  logic [1:0]       port_index,
  input  logic [31:0]      now_time,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic             out_valid,
  output logic [31:0]      out_addr,
  output logic [31:0]      out_mask,
  output logic [31:0]      out_next_hop,
  output logic [7:0]       out_metric,
  output logic             last,
  output logic             changed,
  output logic             status
);

  cmd_t cmd;
  sts_t sts;

  rrte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrte_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_ADVERT  (MAX_ADVERT),
    .NUM_PORTS   (NUM_PORTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (action),
    .dst_addr     (dst_addr),
    .dest_mask    (dest_mask),
    .metric_in    (metric_in),
    .sender_ip    (sender_ip),
    .port_index   (port_index),
    .now_time     (now_time),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .out_valid    (out_valid),
    .out_addr     (out_addr),
    .out_mask     (out_mask),
    .out_next_hop (out_next_hop),
    .out_metric   (out_metric),
    .last         (last),
    .changed      (changed),
    .status       (status)
  );

endmodule

// ----- design/rrte_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rrte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/rrte_ctrl.sv -----
// Sequencing state machine of the route table engine.
// Depends on rrte_pkg; drives commands to rrte_dp and reads its status.
module rrte_ctrl
  import rrte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_LOAD;
      ST_LOAD:  state_next = sts.scan ? ST_READ : ST_FINAL;
      ST_READ:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (!sts.eval_hold) begin
          state_next = sts.eval_last ? ST_FINAL : ST_READ;
        end
      end
      ST_FINAL: if (sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.start = req_valid;
      end
      ST_LOAD:  ;
      ST_READ:  cmd.rd = 1'b1;
      ST_EVAL:  cmd.eval = 1'b1;
      ST_FINAL: cmd.fin = 1'b1;
      default:  ;
    endcase
  end

endmodule

// ----- design/rrte_dp.sv -----
// Datapath: request latch, configuration, route table RAM, scan logic and result register.
// Depends on rrte_pkg and rrte_ram; commanded by rrte_ctrl.
module rrte_dp
  import rrte_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_ADVERT  = 25,
  parameter int NUM_PORTS   = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [2:0]       action,
  input  logic [31:0]      dst_addr,
  input  logic [31:0]      dest_mask,
  input  logic [31:0]      metric_in,
  input  logic [31:0]      sender_ip,
  input  logic [1:0]       port_index,
  input  logic [31:0]      now_time,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic             out_valid,
  output logic [31:0]      out_addr,
  output logic [31:0]      out_mask,
  output logic [31:0]      out_next_hop,
  output logic [7:0]       out_metric,
  output logic             last,
  output logic             changed,
  output logic             status
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = $clog2(MAX_ADVERT + 1);

  // Latched request.
  logic [2:0]  act;
  logic [31:0] addr, mask, min, sender, now;
  logic [1:0]  port;

  logic [7:0]  inf;
  logic [15:0] timeout;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [KW-1:0] k;
  logic found, chg, st, have_pend;
  route_t pend;

  // Derived request values.
  logic        port_ok;
  logic [32:0] sum;
  logic [7:0]  m;
  logic [31:0] key;
  logic        do_rx, do_up, do_down, do_adv, do_tick;

  assign port_ok = ({30'b0, port} < 32'(NUM_PORTS));
  assign sum     = {1'b0, min} + 33'd1;
  assign m       = (sum >= {25'b0, inf}) ? inf : sum[7:0];
  assign key     = addr & mask;
  assign do_rx   = (act == ACT_RX) && port_ok;
  assign do_tick = (act == ACT_TICK);
  assign do_adv  = (act == ACT_ADV);
  assign do_up   = (act == ACT_UP) && port_ok;
  assign do_down = (act == ACT_DOWN) && port_ok;

  // Table RAM.
  route_t r, rec_w, app_rec, wdata;
  logic   ram_we;
  logic [IW-1:0] waddr;

  rrte_ram #(.WIDTH($bits(route_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (r)
  );

  // Per-entry evaluation.
  logic match, ev_wr, ev_stop, ev_found, ev_chg, qual, out_free, push_eval, push_fin;
  logic scan_end, adv_end, need_app, full;

  assign out_free = !rsp_valid || !rsp_stall;
  assign match    = ((r.dest & r.mask) == key);

  always_comb begin
    rec_w    = r;
    ev_wr    = 1'b0;
    ev_stop  = 1'b0;
    ev_found = 1'b0;
    ev_chg   = 1'b0;
    qual     = 1'b0;
    case (act)
      ACT_RX: begin
        if (match) begin
          ev_stop  = 1'b1;
          ev_found = 1'b1;
          if (r.metric != inf && r.gateway == sender) begin
            ev_chg       = (r.metric != m);
            ev_wr        = 1'b1;
            rec_w.metric = m;
            rec_w.stamp  = now;
          end else if (r.metric == inf || m < r.metric) begin
            ev_chg        = 1'b1;
            ev_wr         = 1'b1;
            rec_w.metric  = m;
            rec_w.gateway = sender;
            rec_w.mask    = mask;
            rec_w.stamp   = now;
            rec_w.port    = port;
          end
        end
      end
      ACT_TICK: begin
        if ((now - r.stamp) >= {16'b0, timeout}) begin
          ev_wr        = 1'b1;
          rec_w.metric = inf;
        end
      end
      ACT_ADV: qual = (r.metric != inf);
      ACT_UP: begin
        if (match) begin
          ev_found = 1'b1;
          ev_wr    = 1'b1;
          if (r.metric != inf) begin
            rec_w.stamp = now;
          end else begin
            rec_w.metric  = '0;
            rec_w.port    = port;
            rec_w.gateway = '0;
          end
        end
      end
      ACT_DOWN: begin
        if (r.port == port) begin
          ev_wr        = 1'b1;
          rec_w.metric = inf;
        end
      end
      default: ;
    endcase
  end

  assign scan_end  = ((CW'(idx) + CW'(1)) == count);
  assign adv_end   = qual && ((k + KW'(1)) == KW'(MAX_ADVERT));
  assign push_eval = cmd.eval && qual && have_pend && out_free;
  assign push_fin  = cmd.fin && out_free;
  assign need_app  = (do_rx || do_up) && !found;
  assign full      = (count == CW'(TABLE_DEPTH));

  assign sts.scan      = (do_rx || do_tick || do_adv || do_up || do_down) && (count != '0);
  assign sts.eval_hold = qual && have_pend && !out_free;
  assign sts.eval_last = scan_end || ev_stop || adv_end;
  assign sts.out_free  = out_free;

  always_comb begin
    app_rec.dest    = do_rx ? addr : key;
    app_rec.mask    = mask;
    app_rec.gateway = do_rx ? sender : '0;
    app_rec.metric  = do_rx ? m : '0;
    app_rec.port    = port;
    app_rec.stamp   = now;
  end

  always_comb begin
    ram_we = 1'b0;
    waddr  = idx;
    wdata  = rec_w;
    if (cmd.eval && ev_wr) begin
      ram_we = 1'b1;
    end else if (push_fin && need_app && !full) begin
      ram_we = 1'b1;
      waddr  = count[IW-1:0];
      wdata  = app_rec;
    end
  end

  // Request latch and configuration.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act    <= action;
      addr   <= dst_addr;
      mask   <= dest_mask;
      min    <= metric_in;
      sender <= sender_ip;
      port   <= port_index;
      now    <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inf     <= INF_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_INFINITY) begin
        inf <= cfg_data[7:0];
      end else begin
        timeout <= cfg_data[15:0];
      end
    end
  end

  // Scan control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      k         <= '0;
      found     <= 1'b0;
      chg       <= 1'b0;
      st        <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx       <= '0;
        k         <= '0;
        found     <= 1'b0;
        chg       <= 1'b0;
        st        <= 1'b0;
        have_pend <= 1'b0;
      end
      if (cmd.eval && !sts.eval_hold) begin
        idx <= idx + IW'(1);
        if (ev_found) found <= 1'b1;
        if (ev_chg) chg <= 1'b1;
        if (qual) begin
          have_pend <= 1'b1;
          k         <= k + KW'(1);
        end
      end
      if (push_fin && need_app && !full) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && qual && !sts.eval_hold) begin
      pend.dest    <= r.dest;
      pend.mask    <= r.mask;
      pend.gateway <= r.gateway;
      pend.metric  <= (r.port == port) ? inf : r.metric;
      pend.port    <= r.port;
      pend.stamp   <= r.stamp;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push_eval || push_fin) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_eval || (push_fin && do_adv && have_pend)) begin
      out_valid    <= 1'b1;
      out_addr     <= pend.dest;
      out_mask     <= pend.mask;
      out_next_hop <= pend.gateway;
      out_metric   <= pend.metric;
      last         <= push_fin;
      changed      <= 1'b0;
      status       <= 1'b0;
    end else if (push_fin) begin
      out_valid    <= 1'b0;
      out_addr     <= '0;
      out_mask     <= '0;
      out_next_hop <= '0;
      out_metric   <= '0;
      last         <= 1'b1;
      changed      <= chg || (need_app && !full && do_rx);
      status       <= st || (need_app && full);
    end
  end

endmodule
